>>> design/assert_macros.svh
// assertion macros used by the boundary marker design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/gcb_pkg.sv
// types and helpers for the grapheme cluster boundary marker
package gcb_pkg;

  typedef enum logic [3:0] {
    CLS_OTHER       = 4'd0,
    CLS_CR          = 4'd1,
    CLS_LF          = 4'd2,
    CLS_CONTROL     = 4'd3,
    CLS_EXTEND      = 4'd4,
    CLS_ZWJ         = 4'd5,
    CLS_RI          = 4'd6,
    CLS_PREPEND     = 4'd7,
    CLS_SPACINGMARK = 4'd8,
    CLS_L           = 4'd9,
    CLS_V           = 4'd10,
    CLS_T           = 4'd11,
    CLS_LV          = 4'd12,
    CLS_LVT         = 4'd13
  } gcb_class_t;

  localparam logic [1:0] SAT_MAX = 2'd3;

  typedef struct packed {
    logic [20:0] code_point;
    logic [3:0]  break_class;
    logic        pictographic;
    logic        end_of_text;
  } gcb_in_t;

  typedef struct packed {
    logic [20:0] code_point_out;
    logic        cluster_start;
    logic        text_last;
  } gcb_out_t;

  function automatic logic is_ctl(input logic [3:0] c);
    is_ctl = (c == CLS_CR) || (c == CLS_LF) || (c == CLS_CONTROL);
  endfunction

endpackage

>>> design/grapheme_cluster_boundary.sv
// grapheme cluster boundary marker, top level
//
// src channel: one code point per item with its grapheme break class,
// extended-pictographic flag and end-of-text mark. dst channel: one item
// per source item, in order, carrying the code point, a flag that a new
// cluster starts before it, and the end-of-text mark.
// path: an item taken from src passes through two register stages in all
// (input register, result register) before it reaches dst. throughput:
// one item per cycle unless dst stalls; the boundary decision and the
// running state update are one level of logic from the input register.
// reset clears the running state and both valid flags; the first item
// after reset, and the first after an end-of-text item, starts a cluster.
// when dst stalls the result register holds; src keeps being taken until
// the input register is also full, then src_ready drops.
`include "assert_macros.svh"

module grapheme_cluster_boundary
  import gcb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_ready,
  input  gcb_in_t  src_item,
  output logic     dst_valid,
  input  logic     dst_ready,
  output gcb_out_t dst_item
);

  logic        stage_valid;
  gcb_in_t     stage;
  logic        advance;

  logic        have_previous;
  logic [3:0]  previous_class;
  logic        emoji_prefix_ok;
  logic [1:0]  cluster_length_sat;
  logic [1:0]  regional_count_sat;

  logic        have_previous_next;
  logic [3:0]  previous_class_next;
  logic        emoji_prefix_ok_next;
  logic [1:0]  cluster_length_sat_next;
  logic [1:0]  regional_count_sat_next;

  logic        brk;
  logic [3:0]  cur;
  logic [3:0]  prv;

  assign advance   = stage_valid && (!dst_valid || dst_ready);
  assign src_ready = !stage_valid || advance;
  assign cur       = stage.break_class;
  assign prv       = previous_class;

  // boundary rules in priority order
  always_comb begin
    if (!have_previous) begin
      brk = 1'b1;
    end else if (prv == CLS_CR && cur == CLS_LF) begin
      brk = 1'b0;
    end else if (is_ctl(prv) || is_ctl(cur)) begin
      brk = 1'b1;
    end else if (prv == CLS_L && (cur == CLS_L || cur == CLS_V ||
                                  cur == CLS_LV || cur == CLS_LVT)) begin
      brk = 1'b0;
    end else if ((prv == CLS_LV || prv == CLS_V) && (cur == CLS_V || cur == CLS_T)) begin
      brk = 1'b0;
    end else if ((prv == CLS_LVT || prv == CLS_T) && cur == CLS_T) begin
      brk = 1'b0;
    end else if (cur == CLS_EXTEND || cur == CLS_ZWJ || cur == CLS_SPACINGMARK) begin
      brk = 1'b0;
    end else if (prv == CLS_PREPEND) begin
      brk = 1'b0;
    end else if (stage.pictographic) begin
      brk = !(cluster_length_sat >= 2'd2 && emoji_prefix_ok && prv == CLS_ZWJ);
    end else if (prv == CLS_RI && cur == CLS_RI) begin
      brk = regional_count_sat > 2'd1;
    end else begin
      brk = 1'b1;
    end
  end

  // running state update
  always_comb begin
    have_previous_next      = have_previous;
    previous_class_next     = previous_class;
    emoji_prefix_ok_next    = emoji_prefix_ok;
    cluster_length_sat_next = cluster_length_sat;
    regional_count_sat_next = regional_count_sat;
    if (advance) begin
      if (brk) begin
        emoji_prefix_ok_next    = stage.pictographic;
        cluster_length_sat_next = 2'd1;
        regional_count_sat_next = (cur == CLS_RI) ? 2'd1 : 2'd0;
      end else begin
        if (cluster_length_sat >= 2'd2 && prv != CLS_EXTEND) begin
          emoji_prefix_ok_next = 1'b0;
        end
        if (cluster_length_sat != SAT_MAX) begin
          cluster_length_sat_next = cluster_length_sat + 2'd1;
        end
        if (cur == CLS_RI && regional_count_sat != SAT_MAX) begin
          regional_count_sat_next = regional_count_sat + 2'd1;
        end
      end
      have_previous_next  = 1'b1;
      previous_class_next = cur;
      if (stage.end_of_text) begin
        have_previous_next      = 1'b0;
        previous_class_next     = CLS_OTHER;
        emoji_prefix_ok_next    = 1'b0;
        cluster_length_sat_next = 2'd0;
        regional_count_sat_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid        <= 1'b0;
      dst_valid          <= 1'b0;
      have_previous      <= 1'b0;
      previous_class     <= CLS_OTHER;
      emoji_prefix_ok    <= 1'b0;
      cluster_length_sat <= 2'd0;
      regional_count_sat <= 2'd0;
    end else begin
      if (src_ready) begin
        stage_valid <= src_valid;
      end
      if (advance) begin
        dst_valid <= 1'b1;
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
      have_previous      <= have_previous_next;
      previous_class     <= previous_class_next;
      emoji_prefix_ok    <= emoji_prefix_ok_next;
      cluster_length_sat <= cluster_length_sat_next;
      regional_count_sat <= regional_count_sat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      stage <= src_item;
    end
    if (advance) begin
      dst_item.code_point_out <= stage.code_point;
      dst_item.cluster_start  <= brk;
      dst_item.text_last      <= stage.end_of_text;
    end
  end

  `CHECK_ALWAYS(a_reset_empty, rst |=> !stage_valid && !dst_valid,
                "pipeline not empty after reset")
  `CHECK(a_eot_clears,
         advance && stage.end_of_text |=> !have_previous && cluster_length_sat == 2'd0,
         "state not cleared after end of text")
  `CHECK(a_first_starts, advance && !have_previous |=> dst_item.cluster_start,
         "first item of a text did not start a cluster")
  `CHECK(a_crlf_joined,
         advance && have_previous && prv == CLS_CR && cur == CLS_LF |=> !dst_item.cluster_start,
         "break placed between CR and LF")
  `CHECK(a_break_len, advance && brk && !stage.end_of_text |=> cluster_length_sat == 2'd1,
         "cluster length not restarted at a boundary")

endmodule

>>> sim/testbench.sv
// testbench for the grapheme cluster boundary marker: directed and random texts, scoreboard check
module testbench
  import gcb_pkg::*;
;

  localparam int RANDOM_ITEMS = 850;
  localparam int PHASE_ITEMS  = 150;
  localparam int STUCK_LIMIT  = 200;
  localparam int TAIL_CYCLES  = 10;

  class boundary_tracker;
    bit         seen_any;
    logic [3:0] last_class;
    bit         emoji_run_ok;
    logic [1:0] run_len;
    logic [1:0] ri_count;
    gcb_out_t   expected_marks[$];
    int         mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      seen_any     = 1'b0;
      last_class   = CLS_OTHER;
      emoji_run_ok = 1'b0;
      run_len      = '0;
      ri_count     = '0;
    endfunction

    function bit control_like(logic [3:0] c);
      return c == CLS_CR || c == CLS_LF || c == CLS_CONTROL;
    endfunction

    function bit starts_cluster(logic [3:0] cur, bit pict);
      logic [3:0] prv;
      prv = last_class;
      if (prv == CLS_CR && cur == CLS_LF) return 1'b0;
      if (control_like(prv) || control_like(cur)) return 1'b1;
      if (prv == CLS_L &&
          (cur == CLS_L || cur == CLS_V || cur == CLS_LV || cur == CLS_LVT))
        return 1'b0;
      if ((prv == CLS_LV || prv == CLS_V) && (cur == CLS_V || cur == CLS_T)) return 1'b0;
      if ((prv == CLS_LVT || prv == CLS_T) && cur == CLS_T) return 1'b0;
      if (cur == CLS_EXTEND || cur == CLS_ZWJ || cur == CLS_SPACINGMARK) return 1'b0;
      if (prv == CLS_PREPEND) return 1'b0;
      // emoji zwj sequence joins only onto a pictographic cluster head
      if (pict) return !(run_len >= 2 && emoji_run_ok && prv == CLS_ZWJ);
      if (prv == CLS_RI && cur == CLS_RI) return ri_count > 1;
      return 1'b1;
    endfunction

    function void take_code_point(gcb_in_t item);
      bit       brk;
      gcb_out_t mark;
      brk = seen_any ? starts_cluster(item.break_class, item.pictographic) : 1'b1;
      if (brk) begin
        emoji_run_ok = item.pictographic;
        run_len      = 2'd1;
        ri_count     = (item.break_class == CLS_RI) ? 2'd1 : 2'd0;
      end else begin
        if (run_len >= 2 && last_class != CLS_EXTEND) emoji_run_ok = 1'b0;
        if (run_len < SAT_MAX) run_len++;
        if (item.break_class == CLS_RI && ri_count < SAT_MAX) ri_count++;
      end
      seen_any   = 1'b1;
      last_class = item.break_class;
      mark.code_point_out = item.code_point;
      mark.cluster_start  = brk;
      mark.text_last      = item.end_of_text;
      expected_marks = {expected_marks, mark};
      if (item.end_of_text) clear();
    endfunction

    function void check_marked(gcb_out_t got);
      gcb_out_t want;
      if (expected_marks.size() == 0) begin
        $error("unexpected item code_point_out %0h", got.code_point_out);
        mismatches++;
        return;
      end
      want = expected_marks.pop_front();
      if (got.code_point_out !== want.code_point_out) begin
        $error("code_point_out expected %0h actual %0h",
               want.code_point_out, got.code_point_out);
        mismatches++;
      end
      if (got.cluster_start !== want.cluster_start) begin
        $error("cluster_start expected %0b actual %0b", want.cluster_start, got.cluster_start);
        mismatches++;
      end
      if (got.text_last !== want.text_last) begin
        $error("text_last expected %0b actual %0b", want.text_last, got.text_last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_marks.size();
    endfunction
  endclass

  logic     clk;
  logic     rst = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_ready;
  gcb_in_t  src_item = '0;
  logic     dst_valid;
  logic     dst_ready = 1'b0;
  gcb_out_t dst_item;

  boundary_tracker board = new();
  int src_max_gap = 0;
  int dst_max_stall = 0;
  int sent = 0;
  int stuck_cycles = 0;

  grapheme_cluster_boundary u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_item  (dst_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic gcb_in_t make_item(logic [3:0] cls, bit pict, bit eot);
    gcb_in_t item;
    item.code_point   = 21'($urandom_range(0, 1114111));
    item.break_class  = cls;
    item.pictographic = pict;
    item.end_of_text  = eot;
    return item;
  endfunction

  task automatic send_item(gcb_in_t item);
    repeat ($urandom_range(0, src_max_gap)) begin
      @(negedge clk);
      src_valid <= 1'b0;
    end
    @(negedge clk);
    src_valid <= 1'b1;
    src_item  <= item;
    do @(posedge clk); while (!src_ready);
  endtask

  task automatic send_cp(logic [20:0] cp, logic [3:0] cls, bit pict, bit eot);
    gcb_in_t item;
    item = make_item(cls, pict, eot);
    item.code_point = cp;
    send_item(item);
  endtask

  task automatic drain();
    @(negedge clk);
    src_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic play_random_text();
    gcb_in_t text[$];
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 6))
        0: begin
          text = {text, make_item(CLS_OTHER, 1'b1, 1'b0)};
          repeat ($urandom_range(0, 2))
            text = {text, make_item(CLS_EXTEND, 1'($urandom_range(0, 1)), 1'b0)};
          text = {text, make_item(CLS_ZWJ, 1'b0, 1'b0)};
          text = {text, make_item($urandom_range(0, 1) ? CLS_OTHER : CLS_EXTEND, 1'b1, 1'b0)};
        end
        1: repeat ($urandom_range(1, 5)) text = {text, make_item(CLS_RI, 1'b0, 1'b0)};
        2: repeat ($urandom_range(2, 4))
             text = {text, make_item(4'($urandom_range(CLS_L, CLS_LVT)), 1'b0, 1'b0)};
        3: begin
          text = {text, make_item(CLS_CR, 1'b0, 1'b0)};
          if ($urandom_range(0, 3) != 0) text = {text, make_item(CLS_LF, 1'b0, 1'b0)};
        end
        4: begin
          text = {text, make_item(CLS_PREPEND, 1'b0, 1'b0)};
          text = {text, make_item(4'($urandom_range(0, 15)),
                                  1'($urandom_range(0, 1)), 1'b0)};
          text = {text, make_item(CLS_SPACINGMARK, 1'b0, 1'b0)};
        end
        default: repeat ($urandom_range(1, 4))
          text = {text, make_item(4'($urandom_range(0, 15)),
                                  1'($urandom_range(0, 1)), 1'b0)};
      endcase
    end
    text[text.size() - 1].end_of_text = 1'b1;
    foreach (text[i]) send_item(text[i]);
    sent += text.size();
  endtask

  // scoreboard taps and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (dst_valid && dst_ready) board.check_marked(dst_item);
      if (src_valid && src_ready) board.take_code_point(src_item);
      if ((dst_valid && dst_ready) || (src_valid && src_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
        $display("testbench failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // result side backpressure
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      repeat ($urandom_range(0, dst_max_stall)) begin
        @(negedge clk);
        dst_ready <= 1'b0;
      end
      @(negedge clk);
      dst_ready <= 1'b1;
      do @(posedge clk); while (!dst_valid);
    end
  end

  initial begin
    int phase_end;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed texts
    src_max_gap   = 1;
    dst_max_stall = 1;
    send_cp(21'd0, CLS_OTHER, 1'b0, 1'b0);
    send_cp(21'h00000d, CLS_CR, 1'b0, 1'b0);
    send_cp(21'h00000a, CLS_LF, 1'b0, 1'b0);
    send_cp(21'h000007, CLS_CONTROL, 1'b0, 1'b0);
    send_cp(21'h01f600, CLS_OTHER, 1'b1, 1'b0);
    send_cp(21'h01f3fb, CLS_EXTEND, 1'b0, 1'b0);
    send_cp(21'h00200d, CLS_ZWJ, 1'b0, 1'b0);
    send_cp(21'h002764, CLS_OTHER, 1'b1, 1'b0);
    send_cp(21'h01f1e6, CLS_RI, 1'b0, 1'b0);
    send_cp(21'h01f1e8, CLS_RI, 1'b0, 1'b0);
    send_cp(21'h01f1ea, CLS_RI, 1'b0, 1'b0);
    send_cp(21'h000600, CLS_PREPEND, 1'b0, 1'b0);
    send_cp(21'h001100, CLS_L, 1'b0, 1'b0);
    send_cp(21'h001161, CLS_V, 1'b0, 1'b0);
    send_cp(21'h0011a8, CLS_T, 1'b0, 1'b0);
    send_cp(21'h00ac00, CLS_LV, 1'b0, 1'b0);
    send_cp(21'h0011a8, CLS_T, 1'b0, 1'b0);
    send_cp(21'h00ac01, CLS_LVT, 1'b0, 1'b0);
    send_cp(21'h0011a9, CLS_T, 1'b0, 1'b0);
    send_cp(21'h000903, CLS_SPACINGMARK, 1'b0, 1'b0);
    send_cp(21'h0e0001, 4'd14, 1'b1, 1'b0);
    send_cp(21'h10ffff, 4'd15, 1'b0, 1'b1);
    send_cp(21'h000301, CLS_EXTEND, 1'b0, 1'b0);
    send_cp(21'h00200d, CLS_ZWJ, 1'b0, 1'b0);
    send_cp(21'h01f600, CLS_OTHER, 1'b1, 1'b1);
    drain();

    // random texts in phases of differing pressure
    while (sent < RANDOM_ITEMS) begin
      src_max_gap   = $urandom_range(0, 1) * 3;
      dst_max_stall = $urandom_range(0, 1) * 3;
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end && sent < RANDOM_ITEMS) play_random_text();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+design
design/gcb_pkg.sv
design/grapheme_cluster_boundary.sv
sim/testbench.sv
